// ===== rtl/tdpt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdpt_pkg: shared constants and types of the trial division prime tester
// Widths of the candidate, the trial divisor and the divider's bit counter,
// plus the status record that the divider hands to the controller.
// ----------------------------------------------------------------------------
package tdpt_pkg;

   // Width of the number under test.
   localparam int NUMBER_WIDTH = 32;

   // A divisor never needs to exceed sqrt(2^NUMBER_WIDTH) + 1.
   localparam int DIV_W = NUMBER_WIDTH / 2 + 1;

   // Bit counter of the serial divider counts NUMBER_WIDTH-1 down to 0.
   localparam int CNT_W = $clog2(NUMBER_WIDTH);

   // Configuration register indexes.
   localparam logic REG_EVEN_SCREEN = 1'b0;
   localparam logic REG_SIX_K       = 1'b1;

   // Divider status toward the controller.
   typedef struct packed {
      logic                    done;
      logic [NUMBER_WIDTH-1:0] quotient;
      logic                    rem_zero;
   } div_status_type;

endpackage
`default_nettype wire

// ===== rtl/tdpt_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdpt_divider: bit-serial restoring divider
// Shifts the numerator in one bit per cycle, MSB first, and develops the
// quotient in the same shift register; the remainder stays divisor-wide.
// ----------------------------------------------------------------------------
module tdpt_divider
   import tdpt_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic [NUMBER_WIDTH-1:0] numerator,
   input  wire logic [DIV_W-1:0]        divisor,
   output      div_status_type          status
);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [NUMBER_WIDTH-1:0] work_ff, work_in;
   logic [DIV_W-1:0]        rem_ff, rem_in;
   logic [DIV_W-1:0]        div_ff, div_in;
   logic [DIV_W:0]          trial;
   logic [DIV_W:0]          diff;

   // One restoring step: bring down the next numerator bit and try to subtract.
   assign trial = {rem_ff, work_ff[NUMBER_WIDTH-1]};
   assign diff  = trial - {1'b0, div_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      work_in  = work_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = CNT_W'(NUMBER_WIDTH - 1);
         work_in  = numerator;
         rem_in   = '0;
         div_in   = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in  = diff[DIV_W-1:0];
            work_in = {work_ff[NUMBER_WIDTH-2:0], 1'b1};
         end else begin
            rem_in  = trial[DIV_W-1:0];
            work_in = {work_ff[NUMBER_WIDTH-2:0], 1'b0};
         end
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            count_in = count_ff - CNT_W'(1);
         end
      end
   end

   // Control flags reset; the data path does not need it.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      work_ff  <= work_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
   end

   assign status.done     = done_ff;
   assign status.quotient = work_ff;
   assign status.rem_zero = (rem_ff == '0);

endmodule
`default_nettype wire

// ===== rtl/trial_division_prime_test_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trial_division_prime_test_core: primality test by trial division
// Accepts one 32-bit number per request and returns the number together with
// a flag that tells whether it is prime.
// ----------------------------------------------------------------------------
// Usage:
// A request on req_* carries the candidate; one test runs at a time and
// req_tready is high only while the core is idle. Each result is parked in an
// output register, so a new request is taken while the last result waits.
// Each trial divisor passes through a stepping state and then the bit-serial
// divider. Numbers up to two, and even numbers with even skipping on, answer
// without any divider pass. A 32-bit prime near the top of the range tries
// 32768 divisors. Under the 6k+-1 wheel a skipped divisor only takes a
// stepping state. Writes on csr_* set even skipping (index 0) and the wheel
// (index 1); they are to be made only while the core is idle, which the core
// itself does not enforce. Reset is synchronous and active high: the core
// goes idle, the output register empties, even skipping turns on and the
// wheel off. When the receiver stalls, the result holds in rsp_* and a
// finished test waits until the output register is free.
// ----------------------------------------------------------------------------
module trial_division_prime_test_core
   import tdpt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // Request channel.
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] candidate
   // Response channel.
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [31:0] rsp_tdata,   // [31:0] tested_number
   output      logic [0:0]  rsp_tuser,   // [0] is_prime
   // Configuration write port.
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic        csr_wdata
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_DIVIDE = 2'd1;
   localparam logic [1:0] ST_STEP   = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]              state_ff, state_in;
   logic                    even_screen_ff, even_screen_in;
   logic                    six_k_ff, six_k_in;
   logic [NUMBER_WIDTH-1:0] held_ff, held_in;
   logic [DIV_W-1:0]        divisor_ff, divisor_in;
   logic [2:0]              mod6_ff, mod6_in;
   logic                    prime_ff, prime_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [31:0]             rsp_data_ff, rsp_data_in;
   logic                    rsp_prime_ff, rsp_prime_in;
   logic                    div_start;
   div_status_type          div_status;
   logic                    req_fire;
   logic                    divisor_too_big;
   logic [NUMBER_WIDTH-1:0] req_number;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // Only the low NUMBER_WIDTH bits of the candidate take part.
   assign req_number = NUMBER_WIDTH'(req_tdata);

   // Loop ends once the divisor is larger than the quotient.
   assign divisor_too_big =
      {{(NUMBER_WIDTH - DIV_W){1'b0}}, divisor_ff} > div_status.quotient;

   tdpt_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .numerator (held_ff),
      .divisor   (divisor_in),
      .status    (div_status)
   );

   // Configuration registers.
   always_comb begin
      even_screen_in = even_screen_ff;
      six_k_in       = six_k_ff;
      if (csr_we) begin
         case (csr_index)
            REG_EVEN_SCREEN: even_screen_in = csr_wdata;
            REG_SIX_K:       six_k_in       = csr_wdata;
            default:         ;
         endcase
      end
   end

   // Test sequencer: screens small numbers and, with even skipping on, even numbers, then steps divisors.
   always_comb begin
      state_in     = state_ff;
      held_in      = held_ff;
      divisor_in   = divisor_ff;
      mod6_in      = mod6_ff;
      prime_in     = prime_ff;
      div_start    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_prime_in = rsp_prime_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               held_in = req_number;
               if (req_number < NUMBER_WIDTH'(2)) begin
                  prime_in = 1'b0;
                  state_in = ST_FINISH;
               end else if (req_number == NUMBER_WIDTH'(2)) begin
                  prime_in = 1'b1;
                  state_in = ST_FINISH;
               end else if (!req_number[0]) begin
                  if (even_screen_ff) begin
                     prime_in = 1'b0;
                     state_in = ST_FINISH;
                  end else begin
                     // Try 2 as the first divisor.
                     divisor_in = DIV_W'(2);
                     mod6_in    = 3'd2;
                     state_in   = ST_STEP;
                  end
               end else begin
                  divisor_in = DIV_W'(3);
                  mod6_in    = 3'd3;
                  state_in   = ST_STEP;
               end
            end
         end
         ST_STEP: begin
            // Under the wheel, odd multiples of three past 3 itself are skipped.
            if (six_k_ff && (mod6_ff == 3'd3) && (divisor_ff != DIV_W'(3))) begin
               divisor_in = divisor_ff + DIV_W'(2);
               mod6_in    = 3'd5;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_status.done) begin
               if (divisor_too_big) begin
                  prime_in = 1'b1;
                  state_in = ST_FINISH;
               end else if (div_status.rem_zero) begin
                  prime_in = 1'b0;
                  state_in = ST_FINISH;
               end else begin
                  // Next odd divisor; the residue mod 6 steps through 3, 5, 1 in turn.
                  divisor_in = (divisor_ff == DIV_W'(2)) ? DIV_W'(3)
                                                         : divisor_ff + DIV_W'(2);
                  case (mod6_ff)
                     3'd1:    mod6_in = 3'd3;
                     3'd2:    mod6_in = 3'd3;
                     3'd3:    mod6_in = 3'd5;
                     3'd5:    mod6_in = 3'd1;
                     default: mod6_in = 3'd3;
                  endcase
                  state_in = ST_STEP;
               end
            end
         end
         ST_FINISH: begin
            // Hand the result over once the output register is free.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = 32'(held_ff);
               rsp_prime_in = prime_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         even_screen_ff <= 1'b1;
         six_k_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         even_screen_ff <= even_screen_in;
         six_k_ff       <= six_k_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      held_ff      <= held_in;
      divisor_ff   <= divisor_in;
      mod6_ff      <= mod6_in;
      prime_ff     <= prime_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_prime_ff <= rsp_prime_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_prime_ff;

endmodule
`default_nettype wire

// ===== test/trial_division_prime_test_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trial_division_prime_test_core_tb: self-checking bench of the prime tester
// Sends candidates on the request stream and predicts each verdict in the
// bench. Every result on the response stream is compared with the oldest
// prediction. The run covers small numbers, even numbers in both modes, the
// 6k+-1 wheel, a long output stall and a random mix under changing settings.
// ----------------------------------------------------------------------------
module trial_division_prime_test_core_tb
   import tdpt_pkg::*;
();

   // Clock and reset.
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #5 clock = ~clock;

   // Ports of the block.
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // [31:0] candidate
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // [31:0] tested_number
   logic [0:0]  rsp_tuser;         // [0] is_prime
   logic        csr_we     = 1'b0;
   logic        csr_index  = 1'b0;
   logic        csr_wdata  = 1'b0;

   trial_division_prime_test_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // One verdict as the block should report it.
   typedef struct packed {
      logic [31:0] number;
      logic        is_prime;
   } verdict_type;

   localparam int unsigned RANDOM_ITEMS   = 70;
   // Random candidates that need more loop steps than this are redrawn.
   localparam int unsigned MAX_LOOP_STEPS = 400;
   localparam int unsigned LONG_HOLD      = 300;
   localparam int unsigned WATCHDOG_LIMIT = 60000;

   verdict_type pending_verdicts [$];
   bit          even_screen_mirror = 1'b1;
   bit          wheel_mirror       = 1'b0;
   bit          steady_flow        = 1'b0;
   int unsigned rsp_hold_cycles    = 0;
   int unsigned error_count        = 0;
   int unsigned requests_sent      = 0;
   int unsigned results_checked    = 0;
   int unsigned primes_seen        = 0;
   int unsigned quiet_cycles       = 0;
   bit [3:0]    settings_used      = '0;

   // Trial division as the block performs it; steps counts loop passes.
   // Even numbers above two are composite whether screened or divided by two.
   function automatic bit predict_primality(input logic [31:0] n, input bit wheel,
                                            output int unsigned steps);
      longint unsigned num;
      longint unsigned d;
      bit              prime;
      num   = 64'(n);
      steps = 0;
      prime = 1'b1;
      if (num < 2) begin
         prime = 1'b0;
      end else if (num == 2) begin
         prime = 1'b1;
      end else if (num[0] == 1'b0) begin
         // Either rejected at once or found divisible by two.
         prime = 1'b0;
      end else begin
         d = 3;
         while (prime && d * d <= num) begin
            steps++;
            // Under the wheel, odd multiples of three above three are skipped.
            if (!(wheel && d != 3 && d % 6 == 3) && num % d == 0) begin
               prime = 1'b0;
            end
            d += 2;
         end
      end
      return prime;
   endfunction

   // Random candidate from a mix of sizes, kept short enough to run quickly.
   function automatic logic [31:0] draw_candidate();
      logic [31:0] value;
      int unsigned steps;
      int unsigned pick;
      do begin
         pick = $urandom_range(0, 9);
         if (pick < 4) begin
            value = $urandom_range(0, 300);
         end else if (pick < 6) begin
            value = $urandom_range(0, 70000);
         end else begin
            value = $urandom;
         end
         void'(predict_primality(value, wheel_mirror, steps));
      end while (steps > MAX_LOOP_STEPS);
      return value;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("Mismatch at %0t: %s got 0x%08h, expected 0x%08h", $realtime, what, got, want);
      error_count++;
   endtask

   // Send one request after a random gap (none in steady flow); returns at the falling edge after acceptance.
   task automatic send_candidate(input logic [31:0] value);
      int unsigned gap;
      int unsigned steps;
      verdict_type verdict;
      gap = steady_flow ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      @(posedge clock iff req_tready);
      verdict.number   = value;
      verdict.is_prime = predict_primality(value, wheel_mirror, steps);
      pending_verdicts.insert(pending_verdicts.size(), verdict);
      requests_sent++;
      settings_used[{even_screen_mirror, wheel_mirror}] = 1'b1;
      @(negedge clock);
   endtask

   // Stop offering requests and wait until every verdict has come back.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_verdicts.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_register(input logic index, input logic value);
      drain_results();
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      if (index == REG_EVEN_SCREEN) begin
         even_screen_mirror = value;
      end else begin
         wheel_mirror = value;
      end
   endtask

   // Numbers around the boundary of two under the reset settings.
   task automatic test_small_numbers();
      logic [31:0] list [] = '{0, 1, 2, 3, 4, 5, 7, 9};
      foreach (list[i]) send_candidate(list[i]);
      drain_results();
   endtask

   // Even numbers go through the divisor loop when skipping is off.
   task automatic test_even_divisor();
      logic [31:0] list [] = '{2, 4, 6, 32'hFFFF_FFFE, 32'h8000_0000};
      write_register(REG_EVEN_SCREEN, 1'b0);
      foreach (list[i]) send_candidate(list[i]);
      write_register(REG_EVEN_SCREEN, 1'b1);
   endtask

   // The wheel skips odd multiples of three but must still try three itself.
   task automatic test_six_k_wheel();
      logic [31:0] list [] = '{25, 27, 49, 121, 143, 65521, 65537, 32'hFFFF_FFFF};
      write_register(REG_SIX_K, 1'b1);
      foreach (list[i]) send_candidate(list[i]);
      write_register(REG_SIX_K, 1'b0);
   endtask

   // The receiver holds off while requests keep coming, so the core backs up.
   task automatic test_output_stall();
      drain_results();
      rsp_hold_cycles = LONG_HOLD;
      steady_flow     = 1'b1;
      repeat (8) send_candidate($urandom_range(0, 2000));
      steady_flow = 1'b0;
      drain_results();
   endtask

   // Random candidates in batches, each batch under freshly drawn settings.
   task automatic test_random_mix();
      int unsigned sent;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         write_register(REG_EVEN_SCREEN, 1'($urandom_range(0, 1)));
         write_register(REG_SIX_K, 1'($urandom_range(0, 1)));
         steady_flow = ($urandom_range(0, 3) == 0);
         repeat (10) begin
            send_candidate(draw_candidate());
            sent++;
         end
      end
      steady_flow = 1'b0;
      drain_results();
   endtask

   // Response side: random gaps per result unless in steady flow, plus a long hold-off on demand.
   initial begin
      int unsigned gap;
      @(negedge clock iff !reset);
      forever begin
         if (rsp_hold_cycles != 0) begin
            rsp_tready <= 1'b0;
            repeat (rsp_hold_cycles) @(negedge clock);
            rsp_hold_cycles = 0;
         end
         gap = steady_flow ? 0 : $urandom_range(0, 7);
         if (gap != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock iff rsp_tvalid);
         @(negedge clock);
      end
   end

   // Compare each accepted result with the oldest prediction.
   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_verdicts.size() == 0) begin
            report_mismatch("unexpected result, tested_number", rsp_tdata, 32'h0);
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_tdata !== want.number) begin
               report_mismatch("tested_number", rsp_tdata, want.number);
            end
            if (rsp_tuser[0] !== want.is_prime) begin
               report_mismatch($sformatf("is_prime of %0d", want.number),
                               {31'h0, rsp_tuser[0]}, {31'h0, want.is_prime});
            end
            results_checked++;
            if (want.is_prime) primes_seen++;
         end
      end
   end

   // Watchdog on cycles in which neither stream moves.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout: no request or result moved for %0d cycles", quiet_cycles);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Test sequence.
   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_small_numbers();
      test_even_divisor();
      test_six_k_wheel();
      test_output_stall();
      test_random_mix();
      drain_results();
      repeat (40) @(negedge clock);
      $display("Checked %0d results for %0d requests, %0d of them prime.",
               results_checked, requests_sent, primes_seen);
      $display("Register settings used (even screen, wheel as bit index): 4'b%04b.",
               settings_used);
      if (error_count == 0 && pending_verdicts.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
